FILE: hw/rtl/gsm_pkg.sv
// ----------------------------------------------------------------------------
// gsm_pkg
// Types and constants for the generational slot map handle table.
// ----------------------------------------------------------------------------
package gsm_pkg;

  localparam int SLOTS  = 1024;
  localparam int SLOT_W = 10;
  localparam int GEN_W  = 32;
  localparam int CNT_W  = 11;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_STALE = 3'd3;
  localparam logic [2:0] ST_DEAD  = 3'd4;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_BODY  = 2'd1;
  localparam logic [1:0] KIND_CHAR  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALC_RD,
    S_ALC_WR,
    S_REL_CHK,
    S_REL_RD,
    S_REL_WR,
    S_LKP
  } state_t;

  typedef struct packed {
    logic [GEN_W-1:0]  gen;
    logic [1:0]        kind;
    logic [SLOT_W-1:0] s2d;
  } slot_rec_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
    logic [SLOT_W-1:0] dense;
    logic [1:0]        kind;
    logic              moved;
    logic [SLOT_W-1:0] from;
    logic [CNT_W-1:0]  live;
  } result_t;

endpackage

FILE: hw/rtl/generational_slot_map_unit.sv
// Input is accepted only in the idle state, so one transaction is in flight at a time;
// each one waits on a chain of dependent reads through the two registered-read memories.
// After reset a clearing pass initializes all 1024 slot records and the free/dense
// memory; input is not accepted during that pass.
// ----------------------------------------------------------------------------
// generational_slot_map_unit
// Generational slot map: allocate, release and lookup of handles over a dense
// array. Slot records (generation, kind, dense index) live in one memory; the
// dense-to-slot map and the free stack share a second memory, dense entries
// from the bottom and the free stack mirrored from the top.
// ----------------------------------------------------------------------------
module generational_slot_map_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // slot_index[9:0], handle_gen[41:10], zero fill
  input  logic [3:0]  in_tuser,   // op[1:0], kind[3:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // out_slot[9:0], out_gen[41:10], dense_index[51:42],
                                  // move_from[61:52], live_count[72:62], zero fill
  output logic [5:0]  out_tuser   // status[2:0], slot_kind_out[4:3], moved[5]
);
  import gsm_pkg::*;

  slot_rec_t         mem_a [SLOTS];
  logic [SLOT_W-1:0] mem_b [SLOTS];

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  dense_r, dense_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic              out_valid_r;
  result_t           out_r, res_nxt;
  logic              out_load, out_free, in_acc;

  op_t               op_r;
  logic [SLOT_W-1:0] slot_r;
  logic [GEN_W-1:0]  hgen_r;
  logic [1:0]        kind_r;

  logic              a_re, a_we_gen, a_we_kind, a_we_s2d;
  logic [SLOT_W-1:0] a_raddr, a_waddr;
  slot_rec_t         a_wdata, a_q;
  logic              b_re, b_we;
  logic [SLOT_W-1:0] b_raddr, b_waddr, b_wdata, b_q;

  logic [2:0]        chk;
  logic [SLOT_W-1:0] last;
  logic              moved;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign last       = SLOT_W'(dense_r - CNT_W'(1));
  assign moved      = (a_q.s2d != last);

  always_comb begin
    priority if ({1'b0, slot_r} >= CNT_W'(SLOTS)) chk = ST_RANGE;
    else if (a_q.gen != hgen_r)                   chk = ST_STALE;
    else if (a_q.kind == KIND_EMPTY)              chk = ST_DEAD;
    else                                          chk = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (a_we_gen)  mem_a[a_waddr].gen  <= a_wdata.gen;
    if (a_we_kind) mem_a[a_waddr].kind <= a_wdata.kind;
    if (a_we_s2d)  mem_a[a_waddr].s2d  <= a_wdata.s2d;
    if (a_re)      a_q <= mem_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) mem_b[b_waddr] <= b_wdata;
    if (b_re) b_q <= mem_b[b_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    dense_nxt = dense_r;
    clr_nxt   = clr_r;
    out_load  = 1'b0;
    res_nxt   = '0;
    res_nxt.slot = slot_r;
    res_nxt.live = dense_r;
    a_re      = 1'b0;
    a_raddr   = slot_r;
    a_we_gen  = 1'b0;
    a_we_kind = 1'b0;
    a_we_s2d  = 1'b0;
    a_waddr   = slot_r;
    a_wdata   = '0;
    b_re      = 1'b0;
    b_raddr   = last;
    b_we      = 1'b0;
    b_waddr   = last;
    b_wdata   = slot_r;
    unique case (state_r)
      S_CLEAR: begin
        a_we_gen  = 1'b1;
        a_we_kind = 1'b1;
        a_we_s2d  = 1'b1;
        a_waddr   = clr_r;
        a_wdata   = '{gen: GEN_W'(1), kind: KIND_EMPTY, s2d: '0};
        b_we      = 1'b1;
        b_waddr   = clr_r;
        b_wdata   = clr_r;
        clr_nxt   = clr_r + SLOT_W'(1);
        if (clr_r == SLOT_W'(SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_t'(in_tuser[1:0]))
            OP_ALLOC: begin
              b_re      = 1'b1;
              b_raddr   = dense_r[SLOT_W-1:0];
              state_nxt = S_ALC_RD;
            end
            OP_RELEASE: begin
              a_re      = 1'b1;
              a_raddr   = in_tdata[SLOT_W-1:0];
              state_nxt = S_REL_CHK;
            end
            OP_LOOKUP: begin
              a_re      = 1'b1;
              a_raddr   = in_tdata[SLOT_W-1:0];
              state_nxt = S_LKP;
            end
            OP_NOP: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ALC_RD: begin
        if (dense_r == CNT_W'(SLOTS)) begin
          res_nxt.status = ST_FULL;
          res_nxt.slot   = '0;
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          a_re      = 1'b1;
          a_raddr   = b_q;
          state_nxt = S_ALC_WR;
        end
      end
      S_ALC_WR: begin
        res_nxt.status = ST_OK;
        res_nxt.slot   = b_q;
        res_nxt.gen    = a_q.gen;
        res_nxt.dense  = dense_r[SLOT_W-1:0];
        res_nxt.kind   = (kind_r == KIND_CHAR) ? KIND_CHAR : KIND_BODY;
        res_nxt.live   = dense_r + CNT_W'(1);
        a_waddr        = b_q;
        a_wdata.kind   = res_nxt.kind;
        a_wdata.s2d    = dense_r[SLOT_W-1:0];
        if (out_free) begin
          a_we_kind = 1'b1;
          a_we_s2d  = 1'b1;
          out_load  = 1'b1;
          dense_nxt = dense_r + CNT_W'(1);
          state_nxt = S_IDLE;
        end
      end
      S_REL_CHK: begin
        if (chk != ST_OK || dense_r == '0) begin
          res_nxt.status = (chk != ST_OK) ? chk : ST_DEAD;
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          b_re      = 1'b1;
          b_raddr   = last;
          state_nxt = S_REL_RD;
        end
      end
      S_REL_RD: begin
        a_we_gen     = 1'b1;
        a_we_kind    = 1'b1;
        a_waddr      = slot_r;
        a_wdata.gen  = a_q.gen + GEN_W'(1);
        a_wdata.kind = KIND_EMPTY;
        b_we         = moved;
        b_waddr      = a_q.s2d;
        b_wdata      = b_q;
        state_nxt    = S_REL_WR;
      end
      S_REL_WR: begin
        res_nxt.status = ST_OK;
        res_nxt.gen    = a_q.gen + GEN_W'(1);
        res_nxt.dense  = a_q.s2d;
        res_nxt.kind   = KIND_EMPTY;
        res_nxt.moved  = moved;
        res_nxt.from   = moved ? last : '0;
        res_nxt.live   = dense_r - CNT_W'(1);
        a_waddr        = b_q;
        a_wdata.s2d    = a_q.s2d;
        b_waddr        = last;
        b_wdata        = slot_r;
        if (out_free) begin
          a_we_s2d  = moved;
          b_we      = 1'b1;
          out_load  = 1'b1;
          dense_nxt = dense_r - CNT_W'(1);
          state_nxt = S_IDLE;
        end
      end
      S_LKP: begin
        res_nxt.status = chk;
        if (chk == ST_OK) begin
          res_nxt.gen   = a_q.gen;
          res_nxt.dense = a_q.s2d;
          res_nxt.kind  = a_q.kind;
        end
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      dense_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dense_r <= dense_nxt;
      clr_r   <= clr_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= op_t'(in_tuser[1:0]);
      kind_r <= in_tuser[3:2];
      slot_r <= in_tdata[SLOT_W-1:0];
      hgen_r <= in_tdata[SLOT_W+GEN_W-1:SLOT_W];
    end
    if (out_load) out_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_r.live, out_r.from, out_r.dense, out_r.gen, out_r.slot};
  assign out_tuser  = {out_r.moved, out_r.kind, out_r.status};

  a_dense_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dense_r <= CNT_W'(SLOTS))
    else $error("dense count above table size");

  a_rel_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser[1:0] == OP_RELEASE |=> state_r == S_REL_CHK)
    else $error("release did not enter handle check");

  a_rel_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && state_r == S_REL_WR |=> dense_r == $past(dense_r) - CNT_W'(1))
    else $error("release did not shrink dense array");

  a_alloc_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && op_r == OP_ALLOC && res_nxt.status == ST_OK |-> res_nxt.kind != KIND_EMPTY)
    else $error("allocated slot left empty");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> !$past(out_load))
    else $error("result overwritten while stalled");

endmodule
